// File: src/osm_pkg.sv
// ----------------------------------------------------------------------------
// Operand stack machine package
// Shared sizes, opcode and status codes, and stack cell select codes.
// ----------------------------------------------------------------------------
`default_nettype none

package osm_pkg;

  localparam int unsigned STACK_DEPTH = 128;
  localparam int unsigned ARG_SLOTS   = 128;

  localparam int unsigned CNT_W   = $clog2(STACK_DEPTH + 1);
  localparam int unsigned ARG_AW  = $clog2(ARG_SLOTS);
  localparam int unsigned CMD_W   = 5;
  localparam int unsigned DEPTH_W = 8;

  typedef logic [31:0] word_t;

  typedef enum logic [CMD_W-1:0] {
    OP_POP       = 5'd0,
    OP_PUSHI     = 5'd1,
    OP_DUP       = 5'd2,
    OP_SWAP      = 5'd3,
    OP_SWAP_3RD  = 5'd4,
    OP_JMP       = 5'd5,
    OP_JZ        = 5'd6,
    OP_JPOS      = 5'd7,
    OP_JNEG      = 5'd8,
    OP_ADD       = 5'd9,
    OP_SUB       = 5'd10,
    OP_NEG       = 5'd11,
    OP_PUTC      = 5'd12,
    OP_HALT      = 5'd13,
    OP_AND       = 5'd14,
    OP_OR        = 5'd15,
    OP_ANDN      = 5'd16,
    OP_NOT       = 5'd17,
    OP_ARGCNT    = 5'd18,
    OP_SETCNT    = 5'd19,
    OP_ARGLD     = 5'd20,
    OP_ARGST     = 5'd21
  } op_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_UNDER   = 3'd1,
    ST_OVER    = 3'd2,
    ST_ILLEGAL = 3'd3,
    ST_BADARG  = 3'd4
  } status_e;

  // What a stack cell loads at the next edge.
  typedef enum logic [2:0] {
    SEL_HOLD = 3'd0,
    SEL_UP   = 3'd1,
    SEL_DN1  = 3'd2,
    SEL_DN2  = 3'd3,
    SEL_LOAD = 3'd4
  } cell_sel_e;

endpackage

`default_nettype wire

// File: src/osm_cmd_if.sv
// ----------------------------------------------------------------------------
// Instruction channel
// Carries one fetched instruction per beat with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface osm_cmd_if;
  logic                        valid;
  logic                        ready;
  logic [osm_pkg::CMD_W-1:0]   cmd;
  logic signed [31:0]          immediate;

  modport source (output valid, output cmd, output immediate, input ready);
  modport sink   (input valid, input cmd, input immediate, output ready);
endinterface

`default_nettype wire

// File: src/osm_res_if.sv
// ----------------------------------------------------------------------------
// Result channel
// Carries the outcome of one executed instruction per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface osm_res_if;
  logic                        valid;
  logic                        ready;
  logic [2:0]                  status;
  logic                        branch_taken;
  logic signed [31:0]          branch_offset;
  logic                        char_valid;
  logic [7:0]                  char_out;
  logic                        halted;
  logic signed [31:0]          top_value;
  logic [osm_pkg::DEPTH_W-1:0] stack_depth;

  modport source (output valid, output status, output branch_taken, output branch_offset,
                  output char_valid, output char_out, output halted, output top_value,
                  output stack_depth, input ready);
  modport sink   (input valid, input status, input branch_taken, input branch_offset,
                  input char_valid, input char_out, input halted, input top_value,
                  input stack_depth, output ready);
endinterface

`default_nettype wire

// File: src/osm_stack_cell.sv
// ----------------------------------------------------------------------------
// Stack cell
// Holds one stack entry and loads it from the cell above, from one of the two cells below, or from a load value.
// ----------------------------------------------------------------------------
`default_nettype none

module osm_stack_cell (
  input  wire logic               clk_i,
  input  wire osm_pkg::cell_sel_e sel_i,
  input  wire osm_pkg::word_t     up_i,
  input  wire osm_pkg::word_t     dn1_i,
  input  wire osm_pkg::word_t     dn2_i,
  input  wire osm_pkg::word_t     load_i,
  output osm_pkg::word_t          val_o
);
  import osm_pkg::*;

  word_t val_q, val_d;

  always_comb begin
    unique case (sel_i)
      SEL_UP:   val_d = up_i;
      SEL_DN1:  val_d = dn1_i;
      SEL_DN2:  val_d = dn2_i;
      SEL_LOAD: val_d = load_i;
      default:  val_d = val_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o = val_q;

endmodule

`default_nettype wire

// File: src/osm_arg_file.sv
// ----------------------------------------------------------------------------
// Argument register file
// Memory with one write and one registered read port, valid bits for reset.
// ----------------------------------------------------------------------------
`default_nettype none

module osm_arg_file (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                we_i,
  input  wire logic [osm_pkg::ARG_AW-1:0] waddr_i,
  input  wire osm_pkg::word_t      wdata_i,
  input  wire logic [osm_pkg::ARG_AW-1:0] raddr_i,
  output osm_pkg::word_t           rdata_o
);
  import osm_pkg::*;

  word_t              mem [ARG_SLOTS];
  logic [ARG_SLOTS-1:0] vld_q;
  word_t              mem_rd_q;
  word_t              fwd_q;
  logic               hit_q;
  logic               rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    mem_rd_q <= mem[raddr_i];
    fwd_q    <= wdata_i;
  end

  // A write to the address being read is passed straight through.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      hit_q    <= 1'b0;
      rd_vld_q <= 1'b0;
    end else begin
      if (we_i) begin
        vld_q[waddr_i] <= 1'b1;
      end
      hit_q    <= we_i && (waddr_i == raddr_i);
      rd_vld_q <= vld_q[raddr_i];
    end
  end

  assign rdata_o = hit_q ? fwd_q : (rd_vld_q ? mem_rd_q : '0);

endmodule

`default_nettype wire

// File: src/operand_stack_machine_exec_unit.sv
// ----------------------------------------------------------------------------
// Operand stack machine execution unit
// Executes one fetched instruction per beat on a shifting operand stack.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries one instruction (cmd, immediate) per beat; res_o returns
//   exactly one result beat for every instruction beat, in order.
//   The stack is a row of cells with the top in cell 0; a push shifts every
//   entry one cell down, a pop shifts it up, so each instruction touches
//   only the top three cells plus a uniform shift.
//   An accepted instruction's result beat is presented in the next cycle.
//   Throughput is one instruction per cycle while the receiver takes each
//   result: the stack cells, count and argument file update at the accepting
//   edge, and the next instruction sees the new state at once.
//   The argument file is read at the address held in the next top of stack,
//   so an argument load (which replaces the top) finds its data registered.
//   Results sit in an output register; in_i stays ready while that register
//   is empty or being drained, and stalls while the receiver holds off.
//   After reset the stack is empty, the argument count and all argument
//   slots read as zero, and the unit is not halted. No clearing pass is run.
//   After a halt every instruction is answered with status ok and no effect.
// ----------------------------------------------------------------------------
`default_nettype none

module operand_stack_machine_exec_unit (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  osm_cmd_if.sink     in_i,
  osm_res_if.source   res_o
);
  import osm_pkg::*;

  word_t            cell_val [STACK_DEPTH];
  cell_sel_e        cell_sel [STACK_DEPTH];
  cell_sel_e        shift;
  logic [2:0]       ld_en;
  word_t            ld_val [3];

  logic [CNT_W-1:0] cnt_q, cnt_d;
  word_t            argtot_q, argtot_d;
  logic             halt_q, halt_d;

  logic             res_valid_q;
  status_e          res_status_q;
  logic             res_taken_q;
  word_t            res_offset_q;
  logic             res_cvalid_q;
  logic [7:0]       res_char_q;
  logic             res_halt_q;
  word_t            res_top_q;
  logic [DEPTH_W-1:0] res_depth_q;

  word_t            t0, t1, t2, imm, alu, arg_rd, top_d;
  logic             acc, exec, legal, grow, taken;
  logic [1:0]       need;
  status_e          st;
  logic             arg_we;

  assign t0  = cell_val[0];
  assign t1  = cell_val[1];
  assign t2  = cell_val[2];
  assign imm = word_t'(in_i.immediate);

  assign in_i.ready = !res_valid_q || res_o.ready;
  assign acc        = in_i.valid && in_i.ready;

  // Stack requirements per opcode.
  always_comb begin
    legal = 1'b1;
    need  = 2'd0;
    grow  = 1'b0;
    case (in_i.cmd)
      OP_POP, OP_JZ, OP_JPOS, OP_JNEG, OP_NEG, OP_PUTC, OP_NOT, OP_SETCNT, OP_ARGLD:
        need = 2'd1;
      OP_PUSHI, OP_ARGCNT:
        grow = 1'b1;
      OP_JMP, OP_HALT:
        need = 2'd0;
      OP_DUP: begin
        need = 2'd1;
        grow = 1'b1;
      end
      OP_SWAP, OP_ADD, OP_SUB, OP_AND, OP_OR, OP_ANDN, OP_ARGST:
        need = 2'd2;
      OP_SWAP_3RD:
        need = 2'd3;
      default:
        legal = 1'b0;
    endcase
  end

  always_comb begin
    st = ST_OK;
    if (!halt_q) begin
      if (!legal) begin
        st = ST_ILLEGAL;
      end else if (cnt_q < CNT_W'(need)) begin
        st = ST_UNDER;
      end else if (grow && cnt_q == CNT_W'(STACK_DEPTH)) begin
        st = ST_OVER;
      end else if ((in_i.cmd == OP_ARGLD || in_i.cmd == OP_ARGST) &&
                   t0 >= 32'(ARG_SLOTS)) begin
        st = ST_BADARG;
      end
    end
  end

  assign exec = acc && !halt_q && st == ST_OK;

  always_comb begin
    case (in_i.cmd)
      OP_ADD:  alu = t1 + t0;
      OP_SUB:  alu = t1 - t0;
      OP_AND:  alu = t1 & t0;
      OP_OR:   alu = t1 | t0;
      default: alu = t1 & ~t0;
    endcase
  end

  // Shift pattern and top-cell loads for the executed instruction.
  always_comb begin
    shift     = SEL_HOLD;
    ld_en     = 3'b000;
    ld_val[0] = imm;
    ld_val[1] = t0;
    ld_val[2] = t0;
    taken     = 1'b0;
    halt_d    = halt_q;
    argtot_d  = argtot_q;
    arg_we    = 1'b0;
    if (exec) begin
      case (in_i.cmd)
        OP_POP, OP_PUTC:
          shift = SEL_DN1;
        OP_PUSHI: begin
          shift    = SEL_UP;
          ld_en[0] = 1'b1;
        end
        OP_DUP: begin
          shift     = SEL_UP;
          ld_en[0]  = 1'b1;
          ld_val[0] = t0;
        end
        OP_SWAP: begin
          ld_en[1:0] = 2'b11;
          ld_val[0]  = t1;
        end
        OP_SWAP_3RD: begin
          ld_en     = 3'b101;
          ld_val[0] = t2;
        end
        OP_JMP:
          taken = 1'b1;
        OP_JZ: begin
          shift = SEL_DN1;
          taken = t0 == '0;
        end
        OP_JPOS: begin
          shift = SEL_DN1;
          taken = !t0[31] && t0 != '0;
        end
        OP_JNEG: begin
          shift = SEL_DN1;
          taken = t0[31];
        end
        OP_ADD, OP_SUB, OP_AND, OP_OR, OP_ANDN: begin
          shift     = SEL_DN1;
          ld_en[0]  = 1'b1;
          ld_val[0] = alu;
        end
        OP_NEG: begin
          ld_en[0]  = 1'b1;
          ld_val[0] = '0 - t0;
        end
        OP_NOT: begin
          ld_en[0]  = 1'b1;
          ld_val[0] = ~t0;
        end
        OP_HALT:
          halt_d = 1'b1;
        OP_ARGCNT: begin
          shift     = SEL_UP;
          ld_en[0]  = 1'b1;
          ld_val[0] = argtot_q;
        end
        OP_SETCNT: begin
          shift    = SEL_DN1;
          argtot_d = t0;
        end
        OP_ARGLD: begin
          ld_en[0]  = 1'b1;
          ld_val[0] = arg_rd;
        end
        OP_ARGST: begin
          shift  = SEL_DN2;
          arg_we = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (shift)
      SEL_UP:  cnt_d = cnt_q + CNT_W'(1);
      SEL_DN1: cnt_d = cnt_q - CNT_W'(1);
      SEL_DN2: cnt_d = cnt_q - CNT_W'(2);
      default: cnt_d = cnt_q;
    endcase
  end

  always_comb begin
    if (ld_en[0]) begin
      top_d = ld_val[0];
    end else begin
      case (shift)
        SEL_DN1: top_d = t1;
        SEL_DN2: top_d = t2;
        default: top_d = t0;
      endcase
    end
  end

  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    word_t up_w, dn1_w, dn2_w, load_w;

    if (i < 3) begin : g_top
      assign cell_sel[i] = ld_en[i] ? SEL_LOAD : shift;
      assign load_w      = ld_val[i];
    end else begin : g_body
      assign cell_sel[i] = shift;
      assign load_w      = '0;
    end

    if (i == 0) begin : g_up0
      assign up_w = '0;
    end else begin : g_up
      assign up_w = cell_val[i-1];
    end

    if (i + 1 < STACK_DEPTH) begin : g_dn1
      assign dn1_w = cell_val[i+1];
    end else begin : g_dn1e
      assign dn1_w = '0;
    end

    if (i + 2 < STACK_DEPTH) begin : g_dn2
      assign dn2_w = cell_val[i+2];
    end else begin : g_dn2e
      assign dn2_w = '0;
    end

    osm_stack_cell u_cell (
      .clk_i  (clk_i),
      .sel_i  (cell_sel[i]),
      .up_i   (up_w),
      .dn1_i  (dn1_w),
      .dn2_i  (dn2_w),
      .load_i (load_w),
      .val_o  (cell_val[i])
    );
  end

  osm_arg_file u_args (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (arg_we),
    .waddr_i (t0[ARG_AW-1:0]),
    .wdata_i (t1),
    .raddr_i (top_d[ARG_AW-1:0]),
    .rdata_o (arg_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      argtot_q    <= '0;
      halt_q      <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      cnt_q    <= cnt_d;
      argtot_q <= argtot_d;
      halt_q   <= halt_d;
      if (acc) begin
        res_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      res_status_q <= st;
      res_taken_q  <= taken;
      res_offset_q <= taken ? imm : '0;
      res_cvalid_q <= exec && in_i.cmd == OP_PUTC;
      res_char_q   <= (exec && in_i.cmd == OP_PUTC) ? t0[7:0] : 8'h00;
      res_halt_q   <= halt_d;
      res_top_q    <= (cnt_d != '0) ? top_d : '0;
      res_depth_q  <= DEPTH_W'(cnt_d);
    end
  end

  assign res_o.valid         = res_valid_q;
  assign res_o.status        = res_status_q;
  assign res_o.branch_taken  = res_taken_q;
  assign res_o.branch_offset = res_offset_q;
  assign res_o.char_valid    = res_cvalid_q;
  assign res_o.char_out      = res_char_q;
  assign res_o.halted        = res_halt_q;
  assign res_o.top_value     = res_top_q;
  assign res_o.stack_depth   = res_depth_q;

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(STACK_DEPTH))
    else $error("stack count above depth");

  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halt_q |=> halt_q)
    else $error("halt flag cleared");

  a_err_keeps_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && st != ST_OK) |=> cnt_q == $past(cnt_q) && argtot_q == $past(argtot_q))
    else $error("failing instruction changed state");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |=> res_o.valid)
    else $error("accepted instruction gave no result beat");

  a_halted_no_effect: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && halt_q) |=> cnt_q == $past(cnt_q) && !res_o.branch_taken)
    else $error("instruction executed while halted");
`endif

endmodule

`default_nettype wire
